[rtl/ils_pkg.sv]
package ils_pkg;

   localparam int MAX_SIZE_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int ONE_Q16             = 65536;

   // request opcodes
   localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
   localparam logic [1:0] OP_LOAD_RHS    = 2'd1;
   localparam logic [1:0] OP_START       = 2'd2;

   localparam logic [1:0] METHOD_JACOBI = 2'd0;

   // register indexes
   localparam logic [2:0] CSR_METHOD    = 3'd0;
   localparam logic [2:0] CSR_SIZE      = 3'd1;
   localparam logic [2:0] CSR_RELAX     = 3'd2;
   localparam logic [2:0] CSR_TOLERANCE = 3'd3;
   localparam logic [2:0] CSR_LIMIT     = 3'd4;

   localparam logic [1:0]  RST_METHOD    = 2'd2;
   localparam logic [4:0]  RST_SIZE      = 5'd10;
   localparam logic [17:0] RST_RELAX     = 18'd78643;
   localparam logic [31:0] RST_TOLERANCE = 32'd1;
   localparam logic [15:0] RST_LIMIT     = 16'd1000;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [3:0]         row;
      logic [3:0]         column;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]         index;
      logic signed [31:0] solution;
      logic [15:0]        iterations;
      logic               converged;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  method;
      logic [4:0]  system_size;
      logic [17:0] relaxation;
      logic [31:0] tolerance_squared;
      logic [15:0] iteration_limit;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_ROW, ST_TERM_RD, ST_TERM_LD, ST_MUL_LO, ST_MUL_HI,
      ST_MUL_SUM, ST_TERM_ACC, ST_DIAG_RD, ST_DIAG_LD, ST_DIV_INIT, ST_DIV,
      ST_DIV_END, ST_SOR1, ST_SOR2, ST_SOR_SUM, ST_WRITE, ST_NORM_MAG,
      ST_NORM_SQ, ST_NORM_ADD, ST_CHECK, ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_TERM, PH_SOR1, PH_SOR2
   } phase_type;

   typedef enum logic [4:0] {
      DP_NONE, DP_LOAD_A, DP_LOAD_B, DP_INIT, DP_ROW, DP_RD_A, DP_LOAD_MUL,
      DP_MUL_LO, DP_MUL_HI, DP_MUL_SUM, DP_ACC, DP_RESID, DP_DIV_INIT,
      DP_DIV_STEP, DP_DIV_END, DP_SOR1, DP_SOR2, DP_SOR_SUM, DP_WRITE,
      DP_NORM_MAG, DP_MUL_SQ, DP_NORM_ADD, DP_CHECK
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [4:0] row;
      logic [4:0] col;
      logic [4:0] xi;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic conv;
      logic limit_hit;
   } dp_status_type;

endpackage

[rtl/ils_csr.sv]
module ils_csr import ils_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method            <= RST_METHOD;
         cfg_ff.system_size       <= RST_SIZE;
         cfg_ff.relaxation        <= RST_RELAX;
         cfg_ff.tolerance_squared <= RST_TOLERANCE;
         cfg_ff.iteration_limit   <= RST_LIMIT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_METHOD:    cfg_ff.method            <= csr_data[1:0];
            CSR_SIZE:      cfg_ff.system_size       <= csr_data[4:0];
            CSR_RELAX:     cfg_ff.relaxation        <= csr_data[17:0];
            CSR_TOLERANCE: cfg_ff.tolerance_squared <= csr_data;
            CSR_LIMIT:     cfg_ff.iteration_limit   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

endmodule

[rtl/ils_datapath.sv]
module ils_datapath import ils_pkg::*; #(
   parameter int MAX_SIZE    = MAX_SIZE_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  cfg_type       cfg,
   input  req_type       req_data,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   localparam int CAP = (MAX_SIZE < 16) ? MAX_SIZE : 16;
   localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int AW  = 2 * IW;
   localparam int VW  = VALUE_WIDTH;
   localparam int NW  = VW + 16;
   localparam int CW  = $clog2(NW + 1);
   localparam int PW  = 66;

   localparam logic [PW-1:0]        VMAX_U = (PW'(1) << (VW - 1)) - PW'(1);
   localparam logic signed [PW-1:0] VMAX_P = $signed(VMAX_U);
   localparam logic signed [PW-1:0] VMIN_P = $signed(~VMAX_U);
   localparam logic [VW-1:0]        VMAX_V = {1'b0, {(VW - 1){1'b1}}};
   localparam logic [VW-1:0]        VMIN_V = {1'b1, {(VW - 1){1'b0}}};
   localparam logic [NW-1:0]        QMAX   = NW'(VMAX_V);
   localparam logic [NW-1:0]        QLIM   = QMAX + NW'(1);
   localparam logic signed [PW-1:0] S32MAX = $signed(PW'(32'h7FFF_FFFF));
   localparam logic signed [PW-1:0] S32MIN = $signed(~PW'(32'h7FFF_FFFF));

   function automatic logic [VW-1:0] sat_v(input logic signed [PW-1:0] s);
      if (s > VMAX_P) return VMAX_V;
      else if (s < VMIN_P) return VMIN_V;
      else return s[VW-1:0];
   endfunction

   localparam logic [VW-1:0] SEED = sat_v($signed(PW'(ONE_Q16)));

   // stores
   logic [31:0]   mat_mem [2**AW];
   logic [31:0]   mat_rd_ff;
   logic [31:0]   rhs_ff [CAP];
   logic [VW-1:0] cur_ff [CAP];
   logic [VW-1:0] prev_ff [CAP];

   // arithmetic registers
   logic signed [32:0]   mul_a_ff;
   logic [VW-1:0]        mul_x_ff;
   logic signed [PW-1:0] prod_ff, low_ff;
   logic signed [63:0]   term_ff, acc_ff, sor_ff;
   logic [VW-1:0]        r_ff, g_ff;
   logic [31:0]          diag_ff;
   logic [NW-1:0]        num_ff, q_ff;
   logic [31:0]          den_ff, rem_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 neg_ff, dzero_ff, rpos_ff, rneg_ff, big_ff;
   logic [63:0]          norm_ff;
   logic [15:0]          count_ff;
   logic                 conv_ff;

   logic [IW-1:0]        xi;
   logic [VW-1:0]        cur_rd, prev_rd;
   logic                 row_ok, col_ok, mat_we;
   logic signed [32:0]   mul_lo, mul_hi;
   logic signed [64:0]   acc_wide;
   logic signed [63:0]   acc_in;
   logic [VW-1:0]        r_mag;
   logic [31:0]          d_mag;
   logic [32:0]          rem_sh;
   logic                 rem_ge;
   logic [31:0]          rem_in;
   logic [NW-1:0]        q_neg;
   logic [VW-1:0]        div_res;
   logic signed [VW:0]   diff;
   logic [VW:0]          diff_mag;
   logic [63:0]          m64;
   logic [64:0]          norm_sum;
   logic [63:0]          norm_in;
   logic [15:0]          lim_eff;
   logic signed [PW-1:0] sol_w;

   assign xi      = cmd.xi[IW-1:0];
   assign cur_rd  = cur_ff[xi];
   assign prev_rd = prev_ff[xi];
   assign row_ok  = {1'b0, req_data.row} < 5'(CAP);
   assign col_ok  = {1'b0, req_data.column} < 5'(CAP);
   assign mat_we  = (cmd.op == DP_LOAD_A) && row_ok && col_ok;

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[{req_data.row[IW-1:0], req_data.column[IW-1:0]}] <= req_data.value;
      end
      mat_rd_ff <= mat_mem[{cmd.row[IW-1:0], cmd.col[IW-1:0]}];
   end

   // multiplier operands: x split into unsigned low half and signed high part
   assign mul_lo = $signed({17'b0, mul_x_ff[15:0]});
   assign mul_hi = 33'($signed(mul_x_ff) >>> 16);

   always_comb begin
      acc_wide = 65'(acc_ff) + 65'(term_ff);
      if (acc_wide[64] != acc_wide[63]) begin
         acc_in = acc_wide[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end else begin
         acc_in = acc_wide[63:0];
      end
   end

   assign r_mag = r_ff[VW-1] ? VW'(-r_ff) : r_ff;
   assign d_mag = diag_ff[31] ? 32'(-diag_ff) : diag_ff;

   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign rem_ge = rem_sh >= {1'b0, den_ff};
   assign rem_in = rem_ge ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
   assign q_neg  = -q_ff;

   always_comb begin
      if (dzero_ff) begin
         div_res = rpos_ff ? VMAX_V : (rneg_ff ? VMIN_V : '0);
      end else if (!neg_ff) begin
         div_res = (q_ff > QMAX) ? VMAX_V : q_ff[VW-1:0];
      end else begin
         div_res = (q_ff > QLIM) ? VMIN_V : q_neg[VW-1:0];
      end
   end

   assign diff     = $signed({cur_rd[VW-1], cur_rd}) - $signed({prev_rd[VW-1], prev_rd});
   assign diff_mag = diff[VW] ? (VW + 1)'(-diff) : diff;
   assign m64      = 64'(diff_mag);
   assign norm_sum = {1'b0, norm_ff} + {1'b0, prod_ff[63:0]};
   assign norm_in  = (big_ff || norm_sum[64]) ? '1 : norm_sum[63:0];

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD_B: begin
            if (row_ok) rhs_ff[req_data.row[IW-1:0]] <= req_data.value;
         end
         DP_INIT: begin
            // SOR seeds x[0] with 1.0
            for (int k = 0; k < CAP; k++) begin
               cur_ff[k]  <= (k == 0 && cfg.method[1]) ? SEED : '0;
               prev_ff[k] <= (k == 0 && cfg.method[1]) ? SEED : '0;
            end
         end
         DP_ROW: begin
            acc_ff <= '0;
            if (cmd.xi == 5'd0) norm_ff <= '0;
         end
         DP_RD_A:     mul_x_ff <= (cfg.method == METHOD_JACOBI) ? prev_rd : cur_rd;
         DP_LOAD_MUL: mul_a_ff <= 33'($signed(mat_rd_ff));
         DP_MUL_LO:   prod_ff <= mul_a_ff * mul_lo;
         DP_MUL_HI: begin
            low_ff  <= prod_ff >>> 16;
            prod_ff <= mul_a_ff * mul_hi;
         end
         DP_MUL_SUM:  term_ff <= 64'(prod_ff + low_ff);
         DP_ACC:      acc_ff <= acc_in;
         DP_RESID: begin
            r_ff    <= sat_v(PW'($signed(rhs_ff[xi])) - PW'(acc_ff));
            diag_ff <= mat_rd_ff;
         end
         DP_DIV_INIT: begin
            num_ff   <= {r_mag, 16'b0};
            den_ff   <= d_mag;
            rem_ff   <= '0;
            q_ff     <= '0;
            neg_ff   <= r_ff[VW-1] ^ diag_ff[31];
            dzero_ff <= (diag_ff == 32'd0);
            rpos_ff  <= !r_ff[VW-1] && (r_ff != '0);
            rneg_ff  <= r_ff[VW-1];
         end
         DP_DIV_STEP: begin
            rem_ff <= rem_in;
            q_ff   <= {q_ff[NW-2:0], rem_ge};
            num_ff <= num_ff << 1;
         end
         DP_DIV_END:  g_ff <= div_res;
         DP_SOR1: begin
            mul_a_ff <= $signed(33'(ONE_Q16)) - $signed({15'b0, cfg.relaxation});
            mul_x_ff <= cur_rd;
         end
         DP_SOR2: begin
            sor_ff   <= term_ff;
            mul_a_ff <= $signed({15'b0, cfg.relaxation});
            mul_x_ff <= g_ff;
         end
         DP_SOR_SUM:  g_ff <= sat_v(PW'(sor_ff) + PW'(term_ff));
         DP_WRITE:    cur_ff[xi] <= g_ff;
         DP_NORM_MAG: begin
            big_ff      <= |m64[63:32];
            mul_a_ff    <= $signed({1'b0, m64[31:0]});
            prev_ff[xi] <= cur_rd;
         end
         DP_MUL_SQ:   prod_ff <= mul_a_ff * mul_a_ff;
         DP_NORM_ADD: norm_ff <= norm_in;
         default: ;
      endcase
   end

   // sweep counter, converged flag, divider step count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         conv_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         case (cmd.op)
            DP_INIT: begin
               count_ff <= '0;
               conv_ff  <= 1'b0;
            end
            DP_DIV_INIT: cnt_ff <= CW'(NW);
            DP_DIV_STEP: cnt_ff <= cnt_ff - CW'(1);
            DP_CHECK: begin
               count_ff <= count_ff + 16'd1;
               conv_ff  <= status.conv;
            end
            default: ;
         endcase
      end
   end

   assign lim_eff          = (cfg.iteration_limit == 16'd0) ? 16'd1 : cfg.iteration_limit;
   assign status.div_done  = (cnt_ff == '0);
   assign status.conv      = norm_ff <= {32'b0, cfg.tolerance_squared};
   assign status.limit_hit = ({1'b0, count_ff} + 17'd1) >= {1'b0, lim_eff};

   assign sol_w = PW'($signed(cur_rd));

   always_comb begin
      rsp_data.index = cmd.xi[3:0];
      if (sol_w > S32MAX) rsp_data.solution = 32'sh7FFF_FFFF;
      else if (sol_w < S32MIN) rsp_data.solution = 32'sh8000_0000;
      else rsp_data.solution = sol_w[31:0];
      rsp_data.iterations = count_ff;
      rsp_data.converged  = conv_ff;
      rsp_data.last       = cmd.last;
   end

endmodule

[rtl/ils_controller.sv]
module ils_controller import ils_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  cfg_type       cfg,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int CAP = (MAX_SIZE < 16) ? MAX_SIZE : 16;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [4:0]     i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic           i_last;

   assign i_last = (i_ff + 5'd1) == n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_TERM;
         i_ff     <= '0;
         j_ff     <= '0;
         n_ff     <= 5'd1;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         n_ff     <= n_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      cmd.op    = DP_NONE;
      cmd.row   = i_ff;
      cmd.col   = j_ff;
      cmd.xi    = i_ff;
      cmd.last  = i_last;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req_data.opcode)
                  OP_LOAD_MATRIX: cmd.op = DP_LOAD_A;
                  OP_LOAD_RHS:    cmd.op = DP_LOAD_B;
                  OP_START: begin
                     if (cfg.system_size == 5'd0) n_in = 5'd1;
                     else if (cfg.system_size > 5'(CAP)) n_in = 5'(CAP);
                     else n_in = cfg.system_size;
                     state_in = ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.op   = DP_INIT;
            i_in     = '0;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            cmd.op   = DP_ROW;
            j_in     = '0;
            state_in = ST_TERM_RD;
         end
         ST_TERM_RD: begin
            if (j_ff == n_ff) begin
               state_in = ST_DIAG_RD;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 5'd1;
            end else begin
               cmd.op   = DP_RD_A;
               cmd.xi   = j_ff;
               state_in = ST_TERM_LD;
            end
         end
         ST_TERM_LD: begin
            cmd.op   = DP_LOAD_MUL;
            phase_in = PH_TERM;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.op   = DP_MUL_LO;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.op   = DP_MUL_HI;
            state_in = ST_MUL_SUM;
         end
         ST_MUL_SUM: begin
            cmd.op = DP_MUL_SUM;
            case (phase_ff)
               PH_TERM: state_in = ST_TERM_ACC;
               PH_SOR1: state_in = ST_SOR2;
               default: state_in = ST_SOR_SUM;
            endcase
         end
         ST_TERM_ACC: begin
            cmd.op   = DP_ACC;
            j_in     = j_ff + 5'd1;
            state_in = ST_TERM_RD;
         end
         ST_DIAG_RD: begin
            cmd.col  = i_ff;
            state_in = ST_DIAG_LD;
         end
         ST_DIAG_LD: begin
            cmd.op   = DP_RESID;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.op   = DP_DIV_INIT;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_DIV_END;
            else cmd.op = DP_DIV_STEP;
         end
         ST_DIV_END: begin
            cmd.op   = DP_DIV_END;
            state_in = cfg.method[1] ? ST_SOR1 : ST_WRITE;
         end
         ST_SOR1: begin
            cmd.op   = DP_SOR1;
            phase_in = PH_SOR1;
            state_in = ST_MUL_LO;
         end
         ST_SOR2: begin
            cmd.op   = DP_SOR2;
            phase_in = PH_SOR2;
            state_in = ST_MUL_LO;
         end
         ST_SOR_SUM: begin
            cmd.op   = DP_SOR_SUM;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.op = DP_WRITE;
            if (i_last) begin
               i_in     = '0;
               state_in = ST_NORM_MAG;
            end else begin
               i_in     = i_ff + 5'd1;
               state_in = ST_ROW;
            end
         end
         ST_NORM_MAG: begin
            cmd.op   = DP_NORM_MAG;
            state_in = ST_NORM_SQ;
         end
         ST_NORM_SQ: begin
            cmd.op   = DP_MUL_SQ;
            state_in = ST_NORM_ADD;
         end
         ST_NORM_ADD: begin
            cmd.op = DP_NORM_ADD;
            if (i_last) begin
               i_in     = '0;
               state_in = ST_CHECK;
            end else begin
               i_in     = i_ff + 5'd1;
               state_in = ST_NORM_MAG;
            end
         end
         ST_CHECK: begin
            cmd.op   = DP_CHECK;
            i_in     = '0;
            state_in = (status.conv || status.limit_hit) ? ST_EMIT : ST_ROW;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (i_last) state_in = ST_IDLE;
               else i_in = i_ff + 5'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/iterative_linear_solver_core.sv]
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid/req_stall  | req_data: opcode, row, column, value
// rsp      | out       | rsp_valid/rsp_stall  | rsp_data: index, solution, iterations,
//          |           |                      |           converged, last
// csr      | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Load requests are taken one per cycle while idle. A start request holds
// req_stall high for the whole solve (an init step, then the sweeps). Each
// off-diagonal term goes through the shared 33x33 multiplier as read, load,
// low product, high product, sum and accumulate; each row then forms the
// residual, runs a bit-serial divide (and an SOR blend in SOR mode) and
// writes x, and a norm pass over all rows and a check close each sweep.
// Results then go out one per cycle while rsp_stall is low; the block holds
// the current result during a stall. Reset is synchronous; the matrix and
// rhs stores are not cleared, no clearing pass is run.
module iterative_linear_solver_core import ils_pkg::*; #(
   parameter int MAX_SIZE    = MAX_SIZE_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // configuration registers
   ils_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer: row/term loops, divide, SOR blend, norm pass, emit
   ils_controller #(
      .MAX_SIZE (MAX_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cfg       (cfg),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, multiplier, divider, accumulators
   ils_datapath #(
      .MAX_SIZE    (MAX_SIZE),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/ils_checker.sv]
module ils_checker import ils_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input req_type     req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [31:0] csr_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

   // no request is taken while results go out
   a_no_req_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted during result run");

   // a run continues with the next index until last
   a_run_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=>
         rsp_valid && (rsp_data.index == $past(rsp_data.index) + 4'd1))
      else $error("result run broken");

   // run ends after last
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !rsp_valid)
      else $error("result after last");

endmodule

bind iterative_linear_solver_core ils_checker u_chk (.*);
